FILE: sv/qacss_pkg.sv
// ----------------------------------------------------------------------------
// qacss_pkg
// Shared types and constants for the quote-aware CSV structure scanner:
// word geometry, register codes, reset values and the transfer structs.
// ----------------------------------------------------------------------------
package qacss_pkg;

    // Word geometry
    localparam int BYTES_PER_WORD = 8;
    localparam int CHAR_W         = 8;
    localparam int WORD_W         = BYTES_PER_WORD * CHAR_W;
    localparam int COUNT_W        = 4;
    localparam int POS_W          = 32;
    localparam int ROW_W          = 32;
    localparam int POPCNT_W       = $clog2(BYTES_PER_WORD + 1);
    localparam int CFG_IDX_W      = 2;

    // Register reset values
    localparam logic [CHAR_W-1:0] DELIM_RESET   = 8'd44;
    localparam logic [CHAR_W-1:0] QUOTE_RESET   = 8'd34;
    localparam logic [CHAR_W-1:0] NEWLINE_RESET = 8'd10;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIMITER = 2'd0,
        CFG_QUOTE     = 2'd1,
        CFG_NEWLINE   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [CHAR_W-1:0] delimiter_char;
        logic [CHAR_W-1:0] quote_char;
        logic [CHAR_W-1:0] newline_char;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0]  byte_word;
        logic [COUNT_W-1:0] valid_count;
        logic               restart_stream;
    } t_in;

    typedef struct packed {
        logic [BYTES_PER_WORD-1:0] delimiter_mask;
        logic [BYTES_PER_WORD-1:0] newline_mask;
        logic [BYTES_PER_WORD-1:0] quote_state_mask;
        logic [POS_W-1:0]          word_offset;
        logic [ROW_W-1:0]          rows_total;
    } t_out;

    // What one lane found in its byte
    typedef struct packed {
        logic valid;    // byte lies below the valid count
        logic quote;    // byte is the quote character
        logic delim;    // delimiter candidate (quote meaning wins)
        logic row_nl;   // newline candidate (quote meaning wins)
        logic any_nl;   // byte equals newline_char, sets after_newline
    } t_lane_info;

endpackage

FILE: sv/quote_aware_csv_structure_scanner.sv
// ----------------------------------------------------------------------------
// quote_aware_csv_structure_scanner
// Scans words of up to eight text bytes and marks unquoted delimiters and
// newlines, with the quote state per byte, the word's stream offset and the
// running row count.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_in_data  (t_in)
//   output    out        o_out_valid / i_out_stall  o_out_data (t_out)
//   config    in         i_cfg_wr_en                i_cfg_index, i_cfg_wr_data
//
// One word per cycle while o_in_stall is low; each result is registered in
// the output buffer. The cross-word quote state closes through an eight-lane
// mux chain, which sets the word rate.
// A two-entry output buffer (main plus skid) absorbs a downstream stall;
// o_in_stall rises only when both entries are full.
// Reset is synchronous, active low, and restores the default characters.
// ----------------------------------------------------------------------------
module quote_aware_csv_structure_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  qacss_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output qacss_pkg::t_out                     o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [qacss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [qacss_pkg::CHAR_W-1:0]        i_cfg_wr_data
);

    qacss_pkg::t_cfg                                     r_cfg;
    qacss_pkg::t_lane_info [qacss_pkg::BYTES_PER_WORD-1:0] w_lanes;
    qacss_pkg::t_out                                     w_result;
    qacss_pkg::t_out                                     r_main;
    qacss_pkg::t_out                                     r_skid;
    logic                                                r_main_vld;
    logic                                                r_skid_vld;
    logic [qacss_pkg::COUNT_W-1:0]                       w_count;
    logic                                                w_in_fire;
    logic                                                w_out_fire;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_char <= qacss_pkg::DELIM_RESET;
            r_cfg.quote_char     <= qacss_pkg::QUOTE_RESET;
            r_cfg.newline_char   <= qacss_pkg::NEWLINE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                qacss_pkg::CFG_DELIMITER: r_cfg.delimiter_char <= i_cfg_wr_data;
                qacss_pkg::CFG_QUOTE:     r_cfg.quote_char     <= i_cfg_wr_data;
                qacss_pkg::CFG_NEWLINE:   r_cfg.newline_char   <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Handshakes
    assign o_in_stall = r_skid_vld;
    assign w_in_fire  = i_in_valid & ~r_skid_vld;
    assign w_out_fire = r_main_vld & ~i_out_stall;

    // Clamp the byte count to the word size
    assign w_count = (i_in_data.valid_count > qacss_pkg::COUNT_W'(qacss_pkg::BYTES_PER_WORD))
                   ? qacss_pkg::COUNT_W'(qacss_pkg::BYTES_PER_WORD)
                   : i_in_data.valid_count;

    // Classify each byte in its own lane
    for (genvar g = 0; g < qacss_pkg::BYTES_PER_WORD; g++) begin : g_lane
        qacss_lane u_lane (
            .i_byte  (i_in_data.byte_word[g*qacss_pkg::CHAR_W +: qacss_pkg::CHAR_W]),
            .i_valid (qacss_pkg::COUNT_W'(g) < w_count),
            .i_cfg   (r_cfg),
            .o_info  (w_lanes[g])
        );
    end

    // Combine lanes with the stream state
    qacss_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_in_fire),
        .i_restart (i_in_data.restart_stream),
        .i_count   (w_count),
        .i_lanes   (w_lanes),
        .o_result  (w_result)
    );

    // Output buffer: refill main from skid first, park a new result in skid
    // when main is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_out_fire || !r_main_vld) begin
            if (r_skid_vld) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_main_vld <= w_in_fire;
            end
        end else if (w_in_fire) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire || !r_main_vld) begin
            if (r_skid_vld) begin
                r_main <= r_skid;
            end else if (w_in_fire) begin
                r_main <= w_result;
            end
        end else if (w_in_fire) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid = r_main_vld;
    assign o_out_data  = r_main;

endmodule

FILE: sv/qacss_lane.sv
// ----------------------------------------------------------------------------
// qacss_lane
// One byte lane: compares its byte against the three configured characters
// and reports the classification, gated by the lane's valid flag.
// ----------------------------------------------------------------------------
module qacss_lane (
    input  logic [qacss_pkg::CHAR_W-1:0] i_byte,
    input  logic                         i_valid,
    input  qacss_pkg::t_cfg              i_cfg,
    output qacss_pkg::t_lane_info        o_info
);

    logic w_is_quote;
    logic w_is_delim;
    logic w_is_nl;

    // Match the byte against each configured character
    assign w_is_quote = (i_byte == i_cfg.quote_char);
    assign w_is_delim = (i_byte == i_cfg.delimiter_char);
    assign w_is_nl    = (i_byte == i_cfg.newline_char);

    // Let the quote meaning win over delimiter and newline
    always_comb begin
        o_info.valid  = i_valid;
        o_info.quote  = i_valid & w_is_quote;
        o_info.delim  = i_valid & w_is_delim & ~w_is_quote;
        o_info.row_nl = i_valid & w_is_nl & ~w_is_quote;
        o_info.any_nl = i_valid & w_is_nl;
    end

endmodule

FILE: sv/qacss_merge.sv
// ----------------------------------------------------------------------------
// qacss_merge
// Merging stage: composes the per-lane quote transitions from the stored
// stream state, builds the three masks, counts rows and advances the offset.
// Holds the cross-word stream state.
// ----------------------------------------------------------------------------
module qacss_merge (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_fire,
    input  logic                                            i_restart,
    input  logic [qacss_pkg::COUNT_W-1:0]                   i_count,
    input  qacss_pkg::t_lane_info [qacss_pkg::BYTES_PER_WORD-1:0] i_lanes,
    output qacss_pkg::t_out                                 o_result
);

    logic                          r_in_quote;
    logic                          n_in_quote;
    logic                          r_after_nl;
    logic                          n_after_nl;
    logic [qacss_pkg::POS_W-1:0]   r_pos;
    logic [qacss_pkg::POS_W-1:0]   n_pos;
    logic [qacss_pkg::ROW_W-1:0]   r_rows;
    logic [qacss_pkg::ROW_W-1:0]   n_rows;

    logic                          w_base_q;
    logic                          w_base_a;
    logic [qacss_pkg::POS_W-1:0]   w_base_pos;
    logic [qacss_pkg::ROW_W-1:0]   w_base_rows;
    logic [qacss_pkg::BYTES_PER_WORD-1:0] w_dmask;
    logic [qacss_pkg::BYTES_PER_WORD-1:0] w_nmask;
    logic [qacss_pkg::BYTES_PER_WORD-1:0] w_qmask;
    logic [qacss_pkg::POPCNT_W-1:0]       w_popcnt;
    logic [qacss_pkg::ROW_W:0]            w_row_sum;

    // Start from reset values when the word restarts the stream
    assign w_base_q    = i_restart ? 1'b0 : r_in_quote;
    assign w_base_a    = i_restart ? 1'b1 : r_after_nl;
    assign w_base_pos  = i_restart ? '0   : r_pos;
    assign w_base_rows = i_restart ? '0   : r_rows;

    // Walk the lane transitions: a quote closes an open span, or opens one
    // right after a newline; everything else keeps the state
    always_comb begin
        logic q_prev;
        logic q;
        logic a;
        q        = w_base_q;
        a        = w_base_a;
        w_dmask  = '0;
        w_nmask  = '0;
        w_qmask  = '0;
        w_popcnt = '0;
        for (int i = 0; i < qacss_pkg::BYTES_PER_WORD; i++) begin
            q_prev = q;
            if (i_lanes[i].quote) begin
                q = q_prev ? 1'b0 : a;
            end
            w_dmask[i] = i_lanes[i].delim & ~q_prev;
            w_nmask[i] = i_lanes[i].row_nl & ~q_prev;
            w_qmask[i] = i_lanes[i].valid & q;
            w_popcnt   = w_popcnt + qacss_pkg::POPCNT_W'(w_nmask[i]);
            if (i_lanes[i].valid) begin
                a = i_lanes[i].any_nl;
            end
        end
        n_in_quote = q;
        n_after_nl = a;
    end

    // Saturate the row count, wrap the byte offset
    assign w_row_sum = {1'b0, w_base_rows} + (qacss_pkg::ROW_W + 1)'(w_popcnt);
    assign n_rows    = w_row_sum[qacss_pkg::ROW_W] ? '1 : w_row_sum[qacss_pkg::ROW_W-1:0];
    assign n_pos     = w_base_pos + qacss_pkg::POS_W'(i_count);

    always_comb begin
        o_result.delimiter_mask   = w_dmask;
        o_result.newline_mask     = w_nmask;
        o_result.quote_state_mask = w_qmask;
        o_result.word_offset      = w_base_pos;
        o_result.rows_total       = n_rows;
    end

    // Advance the stream state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote <= 1'b0;
            r_after_nl <= 1'b1;
            r_pos      <= '0;
            r_rows     <= '0;
        end else if (i_fire) begin
            r_in_quote <= n_in_quote;
            r_after_nl <= n_after_nl;
            r_pos      <= n_pos;
            r_rows     <= n_rows;
        end
    end

endmodule

FILE: sv/qacss_checker.sv
// ----------------------------------------------------------------------------
// qacss_checker
// Port-level checks for the scanner: output hold under stall, mask
// consistency and buffer occupancy. Bound to the top level below.
// ----------------------------------------------------------------------------
module qacss_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  qacss_pkg::t_out                     o_out_data
);

    // Hold a stalled result
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("stalled result changed");

    // A reported delimiter or newline never lies inside quotes
    a_delim_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.delimiter_mask & o_out_data.quote_state_mask) == '0))
        else $error("delimiter reported inside quotes");

    a_newline_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.newline_mask & o_out_data.quote_state_mask) == '0))
        else $error("newline reported inside quotes");

    // The input stalls only when the output side is holding a result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

endmodule

bind quote_aware_csv_structure_scanner qacss_checker u_qacss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_data    (o_out_data)
);

FILE: test/csv_index_check_pkg.sv
// ----------------------------------------------------------------------------
// csv_index_check_pkg
// Expected-result tracker for the quote-aware CSV structure scanner. It walks
// each accepted word byte by byte with its own copy of the characters and the
// stream state, queues the masks, offset and row count that word must produce,
// and compares every result transfer field by field against the oldest entry.
// ----------------------------------------------------------------------------
package csv_index_check_pkg;

    import qacss_pkg::*;

    class csv_index_tracker;

        // Character registers as last written
        logic [CHAR_W-1:0] delim_byte;
        logic [CHAR_W-1:0] quote_byte;
        logic [CHAR_W-1:0] newline_byte;

        // Stream state carried across words
        logic              inside_span;
        logic              follows_newline;
        logic [POS_W-1:0]  stream_pos;
        logic [ROW_W-1:0]  rows_counted;

        t_out              expected_scans[$];

        int                mismatches;
        int                words_seen;
        int                restarts_seen;
        int                results_seen;
        int                quoted_lanes;
        int                rows_marked;

        function void clear_stream();
            inside_span     = 1'b0;
            follows_newline = 1'b1;
            stream_pos      = '0;
            rows_counted    = '0;
        endfunction

        function void power_on();
            delim_byte   = DELIM_RESET;
            quote_byte   = QUOTE_RESET;
            newline_byte = NEWLINE_RESET;
            clear_stream();
            expected_scans.delete();
        endfunction

        function void set_register(t_cfg_index idx, logic [CHAR_W-1:0] value);
            case (idx)
                CFG_DELIMITER: delim_byte   = value;
                CFG_QUOTE:     quote_byte   = value;
                CFG_NEWLINE:   newline_byte = value;
                default: ;
            endcase
        endfunction

        // Walk the valid bytes of one word and advance the stream state
        function t_out scan_word(t_in w);
            t_out             r;
            int unsigned      n;
            logic [CHAR_W-1:0] b;
            r = '0;
            if (w.restart_stream) begin
                clear_stream();
            end
            n = (w.valid_count > BYTES_PER_WORD) ? BYTES_PER_WORD : w.valid_count;
            r.word_offset = stream_pos;
            for (int lane = 0; lane < n; lane++) begin
                b = w.byte_word[CHAR_W*lane +: CHAR_W];
                // quote meaning wins over delimiter and newline
                if (b == quote_byte) begin
                    inside_span = inside_span ? 1'b0 : follows_newline;
                end else if (!inside_span) begin
                    if (b == delim_byte) begin
                        r.delimiter_mask[lane] = 1'b1;
                    end
                    if (b == newline_byte) begin
                        r.newline_mask[lane] = 1'b1;
                        if (rows_counted != '1) begin
                            rows_counted++;
                        end
                    end
                end
                r.quote_state_mask[lane] = inside_span;
                follows_newline = (b == newline_byte);
            end
            stream_pos    = stream_pos + n;
            r.rows_total  = rows_counted;
            return r;
        endfunction

        function void note_word(t_in w);
            t_out r;
            r = scan_word(w);
            expected_scans.push_back(r);
            words_seen++;
            if (w.restart_stream) begin
                restarts_seen++;
            end
            quoted_lanes += $countones(r.quote_state_mask);
            rows_marked  += $countones(r.newline_mask);
        endfunction

        function int pending();
            return expected_scans.size();
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH result %0d %s: got %0h expected %0h",
                     results_seen, field, got, want);
            mismatches++;
        endtask

        task check_result(t_out got);
            t_out want;
            results_seen++;
            if (expected_scans.size() == 0) begin
                report("unexpected transfer, rows_total", 64'(got.rows_total), '0);
                return;
            end
            want = expected_scans.pop_front();
            if (got.delimiter_mask !== want.delimiter_mask)
                report("delimiter_mask", 64'(got.delimiter_mask),
                       64'(want.delimiter_mask));
            if (got.newline_mask !== want.newline_mask)
                report("newline_mask", 64'(got.newline_mask), 64'(want.newline_mask));
            if (got.quote_state_mask !== want.quote_state_mask)
                report("quote_state_mask", 64'(got.quote_state_mask),
                       64'(want.quote_state_mask));
            if (got.word_offset !== want.word_offset)
                report("word_offset", 64'(got.word_offset), 64'(want.word_offset));
            if (got.rows_total !== want.rows_total)
                report("rows_total", 64'(got.rows_total), 64'(want.rows_total));
        endtask

    endclass

endpackage

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the quote-aware CSV structure scanner. Six phases, each with
// its own character settings (defaults, extremes, and overlaps of quote,
// delimiter and newline), feed CSV-like text cut into words of random length,
// with noise, restarts and out-of-range counts mixed in; the first phase sends
// directed words first. Sender gaps and receiver stalls vary per phase; every
// result transfer is checked against the tracker.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import qacss_pkg::*;
    import csv_index_check_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int WORDS_PER_PHASE = 306;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data     = '0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CHAR_W-1:0]    i_cfg_wr_data = '0;

    csv_index_tracker     tracker;
    logic [CHAR_W-1:0]    text_backlog[$];
    int                   in_transfers  = 0;
    int                   quiet_cycles  = 0;
    int                   in_gap_pct    = 0;
    int                   out_stall_pct = 0;

    quote_aware_csv_structure_scanner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Randomize downstream back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Track transfers on both channels and watch for a hung pipe
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            tracker.note_word(i_in_data);
            in_transfers++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_out_data);
        end
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("quote_aware_csv_structure_scanner regression: fail");
                $finish;
            end
        end
    end

    // Present one word and hold it until the transfer happens
    task automatic send_word(t_in w);
        int gap;
        int seen;
        gap = 0;
        while ($urandom_range(99) < in_gap_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        seen = in_transfers;
        do @(negedge i_clk); while (in_transfers == seen);
    endtask

    // Write all three character registers on back-to-back cycles
    task automatic load_settings(logic [CHAR_W-1:0] d, logic [CHAR_W-1:0] q,
                                 logic [CHAR_W-1:0] n);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= CFG_DELIMITER;
        i_cfg_wr_data <= d;
        @(negedge i_clk);
        i_cfg_index   <= CFG_QUOTE;
        i_cfg_wr_data <= q;
        @(negedge i_clk);
        i_cfg_index   <= CFG_NEWLINE;
        i_cfg_wr_data <= n;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.set_register(CFG_DELIMITER, d);
        tracker.set_register(CFG_QUOTE, q);
        tracker.set_register(CFG_NEWLINE, n);
    endtask

    function automatic t_in raw_word(logic [WORD_W-1:0] d, logic [COUNT_W-1:0] c,
                                     logic restart);
        t_in w;
        w.byte_word      = d;
        w.valid_count    = c;
        w.restart_stream = restart;
        return w;
    endfunction

    // Text in the low lanes, garbage above it
    function automatic t_in text_word(string s, logic restart);
        t_in w;
        w = raw_word({$urandom, $urandom}, COUNT_W'(s.len()), restart);
        for (int i = 0; i < s.len(); i++) begin
            w.byte_word[CHAR_W*i +: CHAR_W] = s[i];
        end
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] plain_byte();
        return ($urandom_range(1) == 1) ? CHAR_W'($urandom_range(255))
                                        : CHAR_W'($urandom_range(97, 122));
    endfunction

    // Append one CSV record; the first field is quoted half the time
    function automatic void queue_record();
        int fields;
        int len;
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++) begin
            if (f == 0 && $urandom_range(1) == 1) begin
                text_backlog.push_back(tracker.quote_byte);
                len = $urandom_range(0, 6);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(7))
                        6:       text_backlog.push_back(tracker.delim_byte);
                        7:       text_backlog.push_back(tracker.newline_byte);
                        default: text_backlog.push_back(plain_byte());
                    endcase
                end
                text_backlog.push_back(tracker.quote_byte);
            end else begin
                len = $urandom_range(0, 5);
                for (int k = 0; k < len; k++) begin
                    text_backlog.push_back(plain_byte());
                end
            end
            if (f < fields - 1) begin
                text_backlog.push_back(tracker.delim_byte);
            end
        end
        text_backlog.push_back(tracker.newline_byte);
    endfunction

    // Append a short run of structure characters and plain bytes in no particular order
    function automatic void queue_noise();
        int len;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(3))
                0:       text_backlog.push_back(tracker.delim_byte);
                1:       text_backlog.push_back(tracker.quote_byte);
                2:       text_backlog.push_back(tracker.newline_byte);
                default: text_backlog.push_back(plain_byte());
            endcase
        end
    endfunction

    // Cut the next word off the text stream
    function automatic t_in next_word();
        t_in         w;
        int unsigned pick;
        int unsigned take;
        pick = $urandom_range(99);
        w.byte_word      = {$urandom, $urandom};
        w.restart_stream = ($urandom_range(49) == 0);
        if (pick < 3)
            w.valid_count = '0;
        else if (pick < 6)
            w.valid_count = COUNT_W'($urandom_range(9, 15));
        else if (pick < 40)
            w.valid_count = COUNT_W'(BYTES_PER_WORD);
        else
            w.valid_count = COUNT_W'($urandom_range(1, BYTES_PER_WORD));
        take = (w.valid_count > BYTES_PER_WORD) ? BYTES_PER_WORD : w.valid_count;
        while (text_backlog.size() < take) begin
            if ($urandom_range(3) == 0)
                queue_noise();
            else
                queue_record();
        end
        for (int i = 0; i < take; i++) begin
            w.byte_word[CHAR_W*i +: CHAR_W] = text_backlog.pop_front();
        end
        return w;
    endfunction

    // Hand-picked words for the default characters
    task automatic send_directed();
        send_word(text_word("\"a,\nb\",c", 1'b1));   // span opens at stream start
        send_word(text_word("x\"y,z\n\"q", 1'b0));   // stray quote, then span after newline
        send_word(text_word("\n,\"\n", 1'b0));       // newline in span, close, row
        send_word(raw_word({$urandom, $urandom}, 4'd0, 1'b0));
        send_word(raw_word({$urandom, $urandom}, 4'd15, 1'b0));
        send_word(raw_word({$urandom, $urandom}, 4'd9, 1'b0));
        send_word(text_word(",", 1'b0));
        send_word(text_word("ab\"", 1'b1));          // restart mid-stream
        send_word(raw_word({BYTES_PER_WORD{DELIM_RESET}}, 4'd8, 1'b0));
        send_word(raw_word({BYTES_PER_WORD{NEWLINE_RESET}}, 4'd8, 1'b0));
        send_word(raw_word({BYTES_PER_WORD{QUOTE_RESET}}, 4'd8, 1'b0));
        send_word(raw_word('0, 4'd8, 1'b0));
        send_word(raw_word('1, 4'd8, 1'b0));
        send_word(raw_word('0, 4'd0, 1'b1));         // restart with nothing scanned
    endtask

    // One register setting under one flow-control mix, then drain
    task automatic run_phase(int send_pct, int sink_pct, logic [CHAR_W-1:0] d,
                             logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] n,
                             bit with_directed);
        in_gap_pct    = send_pct;
        out_stall_pct = sink_pct;
        load_settings(d, q, n);
        if (with_directed) begin
            send_directed();
        end
        for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            send_word(next_word());
        end
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        tracker = new();
        tracker.power_on();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_phase(13, 74, 8'd44, 8'd34, 8'd10, 1'b1);
        run_phase(74, 13, 8'd0, 8'd255, 8'd128, 1'b0);
        run_phase(0, 0, 8'd255, 8'd0, 8'd255, 1'b0);     // delimiter equals newline
        run_phase(13, 74, 8'd34, 8'd34, 8'd10, 1'b0);    // quote equals delimiter
        run_phase(74, 13, 8'd44, 8'd10, 8'd10, 1'b0);    // quote equals newline
        run_phase(0, 0, 8'd9, 8'd39, 8'd13, 1'b0);

        // Let any stray late result show up
        out_stall_pct = 0;
        repeat (8) @(negedge i_clk);

        $display("Scanned %0d words (%0d restarts) over six character settings and three flow mixes.",
                 tracker.words_seen, tracker.restarts_seen);
        $display("Checked %0d results: %0d quoted lanes, %0d unquoted newlines, %0d mismatches.",
                 tracker.results_seen, tracker.quoted_lanes, tracker.rows_marked,
                 tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("quote_aware_csv_structure_scanner regression: pass");
        end else begin
            $display("quote_aware_csv_structure_scanner regression: fail");
        end
        $finish;
    end

endmodule
